// ===== sv/wgt_pkg.sv =====
package wgt_pkg;

  // data bits beyond this count read as zero, parity included
  localparam int unsigned MaxDataBits = 64;
  localparam int unsigned DataW       = 64;
  localparam int unsigned FrameBitsW  = 7;
  localparam int unsigned TickW       = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  // reset values of the configuration registers
  localparam logic [FrameBitsW-1:0] FrameBitsRst  = 7'd26;
  localparam logic [TickW-1:0]      PulseWidthRst = 16'd100;
  localparam logic [TickW-1:0]      BitPeriodRst  = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_BITS  = 2'd0,
    CFG_PULSE_WIDTH = 2'd1,
    CFG_BIT_PERIOD  = 2'd2
  } wgt_cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PENDING = 3'd1,
    PH_EVEN    = 3'd2,
    PH_DATA    = 3'd3,
    PH_ODD     = 3'd4,
    PH_LAST    = 3'd5
  } wgt_phase_e;

  typedef struct packed {
    logic [FrameBitsW-1:0] frame_bits;
    logic [TickW-1:0]      pulse_width;
    logic [TickW-1:0]      bit_period;
  } wgt_cfg_t;

  // lines[0] drives the zero line, lines[1] the one line
  typedef struct packed {
    wgt_phase_e            phase;
    logic [FrameBitsW-1:0] bit_index;
    logic [TickW-1:0]      tick_count;
    logic [DataW-1:0]      shift_data;
    logic                  first_parity;
    logic                  last_parity;
    logic [1:0]            lines;
  } wgt_state_t;

  // mask of the k leading data bits, bit 63 first
  function automatic logic [DataW-1:0] top_mask(input logic [FrameBitsW-1:0] k);
    logic [FrameBitsW:0] kk;
    logic [DataW-1:0]    m;
    kk = {1'b0, k};
    if (kk > (FrameBitsW+1)'(MaxDataBits)) begin
      kk = (FrameBitsW+1)'(MaxDataBits);
    end
    if (kk >= (FrameBitsW+1)'(DataW)) begin
      m = '1;
    end else begin
      m = ~({DataW{1'b1}} >> kk);
    end
    return m;
  endfunction

  // data bit i of the frame, zero beyond the data width
  function automatic logic frame_bit(input logic [DataW-1:0] d,
                                     input logic [FrameBitsW-1:0] i);
    logic b;
    if (i >= FrameBitsW'(MaxDataBits) || i >= FrameBitsW'(DataW)) begin
      b = 1'b0;
    end else begin
      b = d[~i[5:0]];
    end
    return b;
  endfunction

endpackage

// ===== sv/wgt_in_if.sv =====
interface wgt_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [63:0] card_data;

  modport source (output valid, output cmd, output card_data, input ready);
  modport sink   (input valid, input cmd, input card_data, output ready);
endinterface

// ===== sv/wgt_out_if.sv =====
interface wgt_out_if;
  logic valid;
  logic ready;
  logic line_zero;
  logic line_one;
  logic busy_res;

  modport source (output valid, output line_zero, output line_one, output busy_res,
                  input ready);
  modport sink   (input valid, input line_zero, input line_one, input busy_res,
                  output ready);
endinterface

// ===== sv/wgt_step.sv =====
module wgt_step (
  input  wgt_pkg::wgt_cfg_t          cfg_i,
  input  wgt_pkg::wgt_state_t        cur_i,
  input  logic                       cmd_i,
  input  logic [wgt_pkg::DataW-1:0]  card_data_i,
  output wgt_pkg::wgt_state_t        nxt_o
);

  logic [wgt_pkg::TickW:0]        tick_inc;
  logic [wgt_pkg::FrameBitsW-1:0] n_data;
  logic [wgt_pkg::FrameBitsW-1:0] half;
  logic [wgt_pkg::DataW-1:0]      mask_first;
  logic [wgt_pkg::DataW-1:0]      mask_all;
  logic                           par_first;
  logic                           par_last;
  logic [wgt_pkg::FrameBitsW-1:0] bi_inc;
  logic                           drv_en;
  logic                           drv_bit;
  wgt_pkg::wgt_state_t            bit_st;

  // parities over the latched data
  always_comb begin
    n_data     = (cfg_i.frame_bits >= 7'd2) ? cfg_i.frame_bits - 7'd2 : '0;
    half       = n_data >> 1;
    mask_first = wgt_pkg::top_mask(half);
    mask_all   = wgt_pkg::top_mask(n_data);
    par_first  = ^(cur_i.shift_data & mask_first);
    par_last   = ~(^(cur_i.shift_data & mask_all & ~mask_first));
  end

  // start of the next bit slot
  always_comb begin
    bit_st  = cur_i;
    drv_en  = 1'b0;
    drv_bit = 1'b0;
    if (cur_i.phase == wgt_pkg::PH_PENDING) begin
      bit_st.first_parity = par_first;
      bit_st.last_parity  = par_last;
      bit_st.phase        = wgt_pkg::PH_EVEN;
      bit_st.bit_index    = '0;
    end
    case (bit_st.phase)
      wgt_pkg::PH_EVEN: begin
        drv_en       = 1'b1;
        drv_bit      = bit_st.first_parity;
        bit_st.phase = wgt_pkg::PH_DATA;
      end
      wgt_pkg::PH_DATA: begin
        drv_en  = 1'b1;
        drv_bit = wgt_pkg::frame_bit(cur_i.shift_data, bit_st.bit_index - 7'd1);
      end
      wgt_pkg::PH_ODD: begin
        drv_en       = 1'b1;
        drv_bit      = bit_st.last_parity;
        bit_st.phase = wgt_pkg::PH_LAST;
      end
      default: ;
    endcase
    if (drv_en) begin
      bit_st.lines = bit_st.lines | (drv_bit ? 2'b10 : 2'b01);
    end
    bi_inc = bit_st.bit_index + 7'd1;
    bit_st.bit_index = bi_inc;
    if ({1'b0, cfg_i.frame_bits} <= {1'b0, bi_inc} + 8'd1) begin
      bit_st.bit_index = '0;
      bit_st.phase     = wgt_pkg::PH_ODD;
    end
  end

  always_comb begin
    nxt_o    = cur_i;
    tick_inc = {1'b0, cur_i.tick_count} + 17'd1;
    if (cmd_i) begin
      nxt_o.shift_data = card_data_i;
      nxt_o.phase      = wgt_pkg::PH_PENDING;
    end else if (cur_i.phase != wgt_pkg::PH_IDLE) begin
      if (tick_inc >= {1'b0, cfg_i.bit_period}) begin
        nxt_o            = bit_st;
        nxt_o.tick_count = '0;
      end else begin
        nxt_o.tick_count = tick_inc[wgt_pkg::TickW-1:0];
        if (tick_inc == {1'b0, cfg_i.pulse_width}) begin
          nxt_o.lines = 2'b00;
          if (cur_i.phase == wgt_pkg::PH_LAST) begin
            nxt_o.phase = wgt_pkg::PH_IDLE;
          end
        end
      end
    end
  end

endmodule

// ===== sv/wiegand_transmitter_core.sv =====
// channel  | dir | payload                          | transaction
// ---------+-----+----------------------------------+-----------------------------
// in_i     | in  | cmd, card_data[63:0]             | valid && ready at clk_i rise
// out_o    | out | line_zero, line_one, busy_res    | valid && ready at clk_i rise
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i at clk_i rise
//
// the next state is formed in one pass of wgt_step and stored together with the
// result register, so a transaction can be taken every cycle while out_o does not stall
// in_i is ready whenever the result register is empty or being drained the same cycle
// a stalled result only holds off new input, nothing is dropped
// rst_ni is asynchronous, active low: sender idle, lines released, default timing
module wiegand_transmitter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wgt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wgt_pkg::CfgDataW-1:0]      cfg_data_i,
  wgt_in_if.sink                            in_i,
  wgt_out_if.source                         out_o
);

  wgt_pkg::wgt_cfg_t   cfg_q;
  wgt_pkg::wgt_state_t state_q;
  wgt_pkg::wgt_state_t state_d;
  logic                out_valid_q;
  logic                line_zero_q;
  logic                line_one_q;
  logic                busy_q;
  logic                in_fire;

  // configuration registers, a write lands at the edge where it is enabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_bits  <= wgt_pkg::FrameBitsRst;
      cfg_q.pulse_width <= wgt_pkg::PulseWidthRst;
      cfg_q.bit_period  <= wgt_pkg::BitPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wgt_pkg::CFG_FRAME_BITS:  cfg_q.frame_bits  <= cfg_data_i[wgt_pkg::FrameBitsW-1:0];
        wgt_pkg::CFG_PULSE_WIDTH: cfg_q.pulse_width <= cfg_data_i;
        wgt_pkg::CFG_BIT_PERIOD:  cfg_q.bit_period  <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // take a new item when the result slot is free or emptying now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  wgt_step u_step (
    .cfg_i       (cfg_q),
    .cur_i       (state_q),
    .cmd_i       (in_i.cmd),
    .card_data_i (in_i.card_data),
    .nxt_o       (state_d)
  );

  // sender state: phase, bit position, tick counter, data, parities, lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= wgt_pkg::PH_IDLE;
      state_q.bit_index    <= '0;
      state_q.tick_count   <= '0;
      state_q.shift_data   <= '0;
      state_q.first_parity <= 1'b0;
      state_q.last_parity  <= 1'b0;
      state_q.lines        <= 2'b00;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result register: line levels and busy after each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_zero_q <= state_d.lines[0];
      line_one_q  <= state_d.lines[1];
      busy_q      <= (state_d.phase != wgt_pkg::PH_IDLE);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.line_zero = line_zero_q;
  assign out_o.line_one  = line_one_q;
  assign out_o.busy_res  = busy_q;

  // an idle sender never holds a line
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == wgt_pkg::PH_IDLE |-> state_q.lines == 2'b00)
    else $error("line asserted while sender idle");

  // every accepted item leaves a result behind
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted transaction produced no result");

  // data slots always have a nonzero position
  a_data_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == wgt_pkg::PH_DATA |-> state_q.bit_index != '0)
    else $error("data phase with zero bit position");

  // a start always arms the sender
  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.cmd |=> state_q.phase == wgt_pkg::PH_PENDING)
    else $error("start transaction did not arm sender");

endmodule
